[hw/rtl/gyro_median_angle_integrator_assert.svh]
// Assertion macros shared by the gyro median angle integrator modules
`ifndef GYRO_MEDIAN_ANGLE_INTEGRATOR_ASSERT_SVH
`define GYRO_MEDIAN_ANGLE_INTEGRATOR_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent
`define GMAI_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gmai: same-cycle check failed");

// Check a consequent in the cycle after its antecedent
`define GMAI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gmai: next-cycle check failed");

`endif

[hw/rtl/gmai_pkg.sv]
// Shared types and constants for the gyro median angle integrator
package gmai_pkg;

   localparam int GMAI_QUEUE_DEPTH = 2;

   localparam int SAMPLE_W = 16;
   localparam int SCALE_W  = 16;
   localparam int STEP_W   = 32;
   localparam int DRIFT_W  = 16;
   localparam int RATE_W   = 24;
   localparam int ANGLE_W  = 48;

   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 32;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_RATE_SCALE     = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIME_STEP      = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DRIFT_PER_STEP = 8'd2;

   // register reset values
   localparam logic [SCALE_W-1:0] RATE_SCALE_RST     = 16'd17855;
   localparam logic [STEP_W-1:0]  TIME_STEP_RST      = 32'd4294967;
   localparam logic [DRIFT_W-1:0] DRIFT_PER_STEP_RST = 16'd7662;

   typedef struct packed {
      logic [SCALE_W-1:0] rate_scale;
      logic [STEP_W-1:0]  time_step;
      logic [DRIFT_W-1:0] drift_per_step;
   } gmai_cfg_type;

   // one word handed from the front to the back through the queue
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] median;
      logic signed [RATE_W-1:0]   rate;
   } gmai_entry_type;

endpackage

[hw/rtl/gmai_front.sv]
// Front: sample history, median of three and rate scaling
module gmai_front
   import gmai_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  gmai_cfg_type               cfg,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_raw_rate,
   output logic                       push_valid,
   input  logic                       push_ready,
   output gmai_entry_type             push_entry
);

   localparam int PROD_W = SAMPLE_W + SCALE_W + 1;

   logic signed [SAMPLE_W-1:0] hist0_ff, hist0_in;
   logic signed [SAMPLE_W-1:0] hist1_ff, hist1_in;
   logic                       s1_valid_ff, s1_valid_in;
   logic signed [SAMPLE_W-1:0] s1_med_ff, s1_med_in;
   logic                       s2_valid_ff, s2_valid_in;
   logic signed [SAMPLE_W-1:0] s2_med_ff, s2_med_in;
   logic signed [PROD_W-1:0]   s2_prod_ff, s2_prod_in;

   logic                       req_take;
   logic                       s1_move;
   logic signed [SAMPLE_W-1:0] lo, hi, med;
   logic signed [PROD_W:0]     rnd;

   // stall control
   assign s1_move   = s1_valid_ff && (!s2_valid_ff || push_ready);
   assign req_ready = !s1_valid_ff || s1_move;
   assign req_take  = req_valid && req_ready;

   // median of the two stored samples and the new one
   always_comb begin
      lo = (hist0_ff < hist1_ff) ? hist0_ff : hist1_ff;
      hi = (hist0_ff < hist1_ff) ? hist1_ff : hist0_ff;
      if (req_raw_rate <= lo) begin
         med = lo;
      end else if (req_raw_rate >= hi) begin
         med = hi;
      end else begin
         med = req_raw_rate;
      end
   end

   // advance history and the two front stages
   always_comb begin
      hist0_in    = req_take ? hist1_ff : hist0_ff;
      hist1_in    = req_take ? req_raw_rate : hist1_ff;
      s1_valid_in = req_take || (s1_valid_ff && !s1_move);
      s1_med_in   = req_take ? med : s1_med_ff;
      s2_valid_in = s1_move || (s2_valid_ff && !push_ready);
      s2_med_in   = s1_move ? s1_med_ff : s2_med_ff;
      s2_prod_in  = s1_move ? (s1_med_ff * $signed({1'b0, cfg.rate_scale})) : s2_prod_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist0_ff    <= '0;
         hist1_ff    <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         hist0_ff    <= hist0_in;
         hist1_ff    <= hist1_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      s1_med_ff  <= s1_med_in;
      s2_med_ff  <= s2_med_in;
      s2_prod_ff <= s2_prod_in;
   end

   // negate and round to Q8.16: (128 - p) >> 8, always fits 24 bits
   assign rnd = (PROD_W+1)'(128) - {s2_prod_ff[PROD_W-1], s2_prod_ff};

   assign push_valid        = s2_valid_ff;
   assign push_entry.median = s2_med_ff;
   assign push_entry.rate   = rnd[RATE_W+7:8];

endmodule

[hw/rtl/gmai_queue.sv]
// Short register queue between front and back
module gmai_queue
   import gmai_pkg::*;
#(
   parameter int DEPTH = GMAI_QUEUE_DEPTH
)
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push_valid,
   output logic           push_ready,
   input  gmai_entry_type push_entry,
   output logic           pop_valid,
   input  logic           pop_ready,
   output gmai_entry_type pop_entry
);

`include "gyro_median_angle_integrator_assert.svh"

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   gmai_entry_type   mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_entry  = mem_ff[rd_ptr_ff];

   // advance pointers with wrap and track fill
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store a word
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `GMAI_ASSERT_NOW(a_q_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH))
   `GMAI_ASSERT_NEXT(a_q_fill_up, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1)
   `GMAI_ASSERT_NEXT(a_q_drain, clock, reset, pop && !push, count_ff == $past(count_ff) - 1'b1)

endmodule

[hw/rtl/gmai_back.sv]
// Back: rate times time step, drift correction and saturating angle accumulator
module gmai_back
   import gmai_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  gmai_cfg_type               cfg,
   input  logic                       pop_valid,
   output logic                       pop_ready,
   input  gmai_entry_type             pop_entry,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_filtered_rate,
   output logic signed [RATE_W-1:0]   rsp_angular_rate,
   output logic signed [ANGLE_W-1:0]  rsp_heading_angle,
   output logic                       rsp_angle_saturated
);

`include "gyro_median_angle_integrator_assert.svh"

   localparam int PROD_W = RATE_W + STEP_W + 1;
   localparam int INC_W  = PROD_W - 16;
   localparam int SUM_W  = ANGLE_W + 2;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_RND  = 2'd2;
   localparam logic [1:0] ST_ACC  = 2'd3;

   localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = {1'b0, {(ANGLE_W-1){1'b1}}};
   localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = {1'b1, {(ANGLE_W-1){1'b0}}};

   logic [1:0]                 state_ff, state_in;
   logic signed [SAMPLE_W-1:0] med_ff, med_in;
   logic signed [RATE_W-1:0]   rate_ff, rate_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [INC_W-1:0]    inc_ff, inc_in;
   logic signed [ANGLE_W-1:0]  accum_ff, accum_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_med_ff, rsp_med_in;
   logic signed [RATE_W-1:0]   rsp_rate_ff, rsp_rate_in;
   logic signed [ANGLE_W-1:0]  rsp_angle_ff, rsp_angle_in;
   logic                       rsp_sat_ff, rsp_sat_in;

   logic                       out_free;
   logic                       acc_done;
   logic signed [PROD_W-1:0]   prod_rnd;
   logic signed [SUM_W-1:0]    sum;
   logic                       over, under;
   logic signed [ANGLE_W-1:0]  clipped;

   assign pop_ready = (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign acc_done  = (state_ff == ST_ACC) && out_free;

   // round the Q.48 increment to Q.32
   assign prod_rnd = prod_ff + PROD_W'(32768);

   // add increment, subtract drift, clip to the 48-bit range
   always_comb begin
      sum = {{(SUM_W-ANGLE_W){accum_ff[ANGLE_W-1]}}, accum_ff}
          + {{(SUM_W-INC_W){inc_ff[INC_W-1]}}, inc_ff}
          - {{(SUM_W-DRIFT_W){1'b0}}, cfg.drift_per_step};
      over  = !sum[SUM_W-1] && (sum[SUM_W-2] || sum[SUM_W-3]);
      under = sum[SUM_W-1] && !(sum[SUM_W-2] && sum[SUM_W-3]);
      if (over) begin
         clipped = ANGLE_MAX;
      end else if (under) begin
         clipped = ANGLE_MIN;
      end else begin
         clipped = sum[ANGLE_W-1:0];
      end
   end

   // sequence one word through multiply, round and accumulate
   always_comb begin
      state_in     = state_ff;
      med_in       = med_ff;
      rate_in      = rate_ff;
      prod_in      = prod_ff;
      inc_in       = inc_ff;
      accum_in     = accum_ff;
      rsp_med_in   = rsp_med_ff;
      rsp_rate_in  = rsp_rate_ff;
      rsp_angle_in = rsp_angle_ff;
      rsp_sat_in   = rsp_sat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               med_in   = pop_entry.median;
               rate_in  = pop_entry.rate;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = rate_ff * $signed({1'b0, cfg.time_step});
            state_in = ST_RND;
         end
         ST_RND: begin
            inc_in   = prod_rnd[PROD_W-1:16];
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (out_free) begin
               accum_in     = clipped;
               rsp_med_in   = med_ff;
               rsp_rate_in  = rate_ff;
               rsp_angle_in = clipped;
               rsp_sat_in   = over || under;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         accum_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         accum_ff     <= accum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      med_ff       <= med_in;
      rate_ff      <= rate_in;
      prod_ff      <= prod_in;
      inc_ff       <= inc_in;
      rsp_med_ff   <= rsp_med_in;
      rsp_rate_ff  <= rsp_rate_in;
      rsp_angle_ff <= rsp_angle_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_filtered_rate   = rsp_med_ff;
   assign rsp_angular_rate    = rsp_rate_ff;
   assign rsp_heading_angle   = rsp_angle_ff;
   assign rsp_angle_saturated = rsp_sat_ff;

   `GMAI_ASSERT_NOW(a_sat_at_limit, clock, reset, rsp_valid_ff && rsp_sat_ff, rsp_angle_ff == ANGLE_MAX || rsp_angle_ff == ANGLE_MIN)
   `GMAI_ASSERT_NEXT(a_acc_holds, clock, reset, state_ff == ST_ACC && !out_free, state_ff == ST_ACC && $stable(accum_ff))
   `GMAI_ASSERT_NEXT(a_pop_starts, clock, reset, state_ff == ST_IDLE && pop_valid, state_ff == ST_MUL)
   `GMAI_ASSERT_NEXT(a_acc_reports, clock, reset, acc_done, rsp_valid_ff && rsp_angle_ff == accum_ff)

endmodule

[hw/rtl/gyro_median_angle_integrator.sv]
// Top level: control registers, front, queue and back of the gyro angle integrator
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_ready  req_raw_rate
//   rsp_     out        rsp_valid/rsp_ready  rsp_filtered_rate, rsp_angular_rate,
//                                            rsp_heading_angle, rsp_angle_saturated
//   csr_     in         csr_valid/csr_ready  csr_index, csr_wdata
//
// The front takes a word every cycle while the queue has room, into its two stages
// (median, scale multiply). The back steps each word through pop, rate times time
// step, rounding and accumulate, and pops no new word until the last is accumulated.
// Each word passes the front stages, queue and back sequencer to the output register.
// Reset clears sample history, accumulator and registers to their defaults.
// A stalled result holds in the output register; the queue lets the front run ahead.
module gyro_median_angle_integrator
   import gmai_pkg::*;
#(
   parameter int QUEUE_DEPTH = GMAI_QUEUE_DEPTH
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_raw_rate,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_filtered_rate,
   output logic signed [RATE_W-1:0]   rsp_angular_rate,
   output logic signed [ANGLE_W-1:0]  rsp_heading_angle,
   output logic                       rsp_angle_saturated,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata
);

   gmai_cfg_type   cfg_ff, cfg_in;
   logic           push_valid, push_ready;
   gmai_entry_type push_entry;
   logic           pop_valid, pop_ready;
   gmai_entry_type pop_entry;

   assign csr_ready = 1'b1;

   // decode register writes, drop unknown indexes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_RATE_SCALE:     cfg_in.rate_scale     = csr_wdata[SCALE_W-1:0];
            CSR_TIME_STEP:      cfg_in.time_step      = csr_wdata[STEP_W-1:0];
            CSR_DRIFT_PER_STEP: cfg_in.drift_per_step = csr_wdata[DRIFT_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rate_scale     <= RATE_SCALE_RST;
         cfg_ff.time_step      <= TIME_STEP_RST;
         cfg_ff.drift_per_step <= DRIFT_PER_STEP_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   gmai_front u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_raw_rate (req_raw_rate),
      .push_valid   (push_valid),
      .push_ready   (push_ready),
      .push_entry   (push_entry)
   );

   gmai_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   gmai_back u_back (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg_ff),
      .pop_valid           (pop_valid),
      .pop_ready           (pop_ready),
      .pop_entry           (pop_entry),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_filtered_rate   (rsp_filtered_rate),
      .rsp_angular_rate    (rsp_angular_rate),
      .rsp_heading_angle   (rsp_heading_angle),
      .rsp_angle_saturated (rsp_angle_saturated)
   );

endmodule

[test/gyro_median_angle_integrator_test.sv]
// Testbench for the gyro median filter and heading angle integrator
module gyro_median_angle_integrator_test;
   timeunit 1ns;
   timeprecision 1ps;

   import gmai_pkg::*;

   localparam int     SETTLE_CYCLES   = 12;
   localparam int     HOLD_OFF_CYCLES = 80;
   localparam int     QUIET_LIMIT     = 4000;
   localparam int     REPORT_LIMIT    = 10;
   localparam longint ANGLE_TOP       = (64'sd1 <<< (ANGLE_W - 1)) - 1;
   localparam longint ANGLE_BOTTOM    = -(64'sd1 <<< (ANGLE_W - 1));

   typedef enum int {SAMPLES_ANY, SAMPLES_HIGH, SAMPLES_LOW} sample_kind_type;
   typedef enum int {READY_ALWAYS, READY_HALF, READY_SPARSE, READY_PERIODIC} ready_mode_type;

   typedef struct {
      logic signed [SAMPLE_W-1:0] filtered;
      logic signed [RATE_W-1:0]   rate;
      logic signed [ANGLE_W-1:0]  angle;
      logic                       clipped;
   } heading_word_type;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_raw_rate;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_filtered_rate;
   logic signed [RATE_W-1:0]   rsp_angular_rate;
   logic signed [ANGLE_W-1:0]  rsp_heading_angle;
   logic                       rsp_angle_saturated;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_INDEX_W-1:0]     csr_index;
   logic [CSR_DATA_W-1:0]      csr_wdata;

   // predictor state and register copy
   gmai_cfg_type               model_cfg;
   logic signed [SAMPLE_W-1:0] model_history [2];
   longint                     model_angle;
   int                         clip_count;
   heading_word_type           pending_results[$];

   int error_count  = 0;
   int result_count = 0;
   int quiet_cycles = 0;

   // receiver hold-off requests
   int             hold_off_asked = 0;
   int             hold_off_seen  = 0;
   int             hold_left      = 0;
   int             mode_left      = 0;
   ready_mode_type ready_mode     = READY_ALWAYS;

   gyro_median_angle_integrator i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_raw_rate        (req_raw_rate),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_filtered_rate   (rsp_filtered_rate),
      .rsp_angular_rate    (rsp_angular_rate),
      .rsp_heading_angle   (rsp_heading_angle),
      .rsp_angle_saturated (rsp_angle_saturated),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   // Filter one raw sample, scale and integrate it, queue the expected word
   task automatic integrate_sample(input logic signed [SAMPLE_W-1:0] raw_value);
      logic signed [SAMPLE_W-1:0] older, newer, lo, hi, median;
      longint                     scaled, rate, delta, sum;
      heading_word_type           word;
      older  = model_history[0];
      newer  = model_history[1];
      lo     = (older < newer) ? older : newer;
      hi     = (older < newer) ? newer : older;
      if (raw_value <= lo)
         median = lo;
      else if (raw_value >= hi)
         median = hi;
      else
         median = raw_value;
      model_history[0] = newer;
      model_history[1] = raw_value;

      // Q0.24 scale times integer sample, negated, rounded to Q8.16
      scaled = -(longint'(median) * longint'(model_cfg.rate_scale));
      rate   = (scaled + 128) >>> 8;
      // Q8.16 times Q0.32 rounded to Q8.32, less the drift
      delta  = (rate * longint'(model_cfg.time_step) + 32768) >>> 16;
      sum    = model_angle + delta - longint'(model_cfg.drift_per_step);
      word.clipped = 1'b0;
      if (sum > ANGLE_TOP) begin
         sum = ANGLE_TOP;
         word.clipped = 1'b1;
      end
      if (sum < ANGLE_BOTTOM) begin
         sum = ANGLE_BOTTOM;
         word.clipped = 1'b1;
      end
      if (word.clipped)
         clip_count++;
      model_angle   = sum;
      word.filtered = median;
      word.rate     = rate[RATE_W-1:0];
      word.angle    = sum[ANGLE_W-1:0];
      pending_results.push_back(word);
   endtask

   // ---------------------------------------------------------------- checking

   task automatic note_error(input string msg);
      error_count++;
      if (error_count <= REPORT_LIMIT)
         $display("%s", msg);
   endtask

   task automatic check_field(input string name, input logic signed [63:0] want,
                              input logic signed [63:0] got);
      if (got !== want)
         note_error($sformatf("ERROR: result %0d %s expected %0d got %0d",
                              result_count, name, want, got));
   endtask

   // Compare every accepted result word with the oldest expectation
   always @(posedge clock) begin
      heading_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            note_error($sformatf("ERROR: result %0d arrived with nothing expected",
                                 result_count));
         end else begin
            want = pending_results.pop_front();
            check_field("filtered_rate", want.filtered, rsp_filtered_rate);
            check_field("angular_rate", want.rate, rsp_angular_rate);
            check_field("heading_angle", want.angle, rsp_heading_angle);
            check_field("angle_saturated", {63'd0, want.clipped},
                        {63'd0, rsp_angle_saturated});
         end
         result_count++;
      end
   end

   // End the run when no word moves for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // ---------------------------------------------------------------- receiver

   // Stall the result channel on a pattern of its own, with long hold-offs on request
   always @(negedge clock) begin
      if (hold_off_seen != hold_off_asked) begin
         hold_off_seen = hold_off_asked;
         hold_left     = HOLD_OFF_CYCLES;
      end
      if (mode_left == 0) begin
         ready_mode = ready_mode_type'($urandom_range(0, 3));
         mode_left  = $urandom_range(10, 60);
      end
      mode_left--;
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         case (ready_mode)
            READY_ALWAYS:  rsp_ready <= 1'b1;
            READY_HALF:    rsp_ready <= 1'($urandom_range(0, 1));
            READY_SPARSE:  rsp_ready <= ($urandom_range(0, 3) == 0);
            default:       rsp_ready <= (mode_left % 3 == 0);
         endcase
      end
   end

   // ---------------------------------------------------------------- sender

   // Offer one sample word and hold it until accepted
   task automatic send_word(input logic signed [SAMPLE_W-1:0] raw_value);
      @(negedge clock);
      req_valid    <= 1'b1;
      req_raw_rate <= raw_value;
      do @(posedge clock); while (!req_ready);
      integrate_sample(raw_value);
   endtask

   // Drop valid for a number of cycles
   task automatic idle_requests(input int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // Wait for every expected word, then let the pipeline settle
   task automatic wait_until_idle();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      wait_until_idle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_RATE_SCALE:     model_cfg.rate_scale     = value[SCALE_W-1:0];
         CSR_TIME_STEP:      model_cfg.time_step      = value[STEP_W-1:0];
         CSR_DRIFT_PER_STEP: model_cfg.drift_per_step = value[DRIFT_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic signed [SAMPLE_W-1:0] pick_sample(input sample_kind_type kind);
      logic signed [SAMPLE_W-1:0] value;
      value = SAMPLE_W'($urandom);
      case (kind)
         SAMPLES_HIGH: begin
            if ($urandom_range(0, 7) != 0) value = SAMPLE_W'($urandom_range(30000, 32767));
         end
         SAMPLES_LOW: begin
            if ($urandom_range(0, 7) != 0) value = SAMPLE_W'(-$urandom_range(30000, 32768));
         end
         default: begin
            if ($urandom_range(0, 7) == 0) begin
               case ($urandom_range(0, 3))
                  0:       value = 16'sh8000;
                  1:       value = 16'sh7FFF;
                  2:       value = 16'sh0000;
                  default: value = 16'shFFFF;
               endcase
            end
         end
      endcase
      return value;
   endfunction

   // Random register value; low field bits at an extreme half of the time
   function automatic logic [CSR_DATA_W-1:0] pick_register_value(input int width);
      logic [CSR_DATA_W-1:0] mask, value;
      mask  = (width >= CSR_DATA_W) ? '1 : ((32'd1 << width) - 1);
      value = $urandom;
      case ($urandom_range(0, 3))
         0:       value = value & ~mask;
         1:       value = value | mask;
         default: ;
      endcase
      return value;
   endfunction

   // Send words in bursts of random length with random gaps; stop early on clips
   task automatic send_stream(input int count, input sample_kind_type kind,
                              input int clip_goal);
      int sent, burst_left, clips_at_start;
      sent           = 0;
      burst_left     = 0;
      clips_at_start = clip_count;
      while (sent < count && (clip_goal == 0 || clip_count - clips_at_start < clip_goal)) begin
         if (burst_left == 0) begin
            if (sent > 0)
               idle_requests($urandom_range(1, 8));
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                    : $urandom_range(1, 12);
         end
         send_word(pick_sample(kind));
         sent++;
         burst_left--;
      end
      idle_requests(1);
   endtask

   // ---------------------------------------------------------------- tests

   // Median cases and sample extremes at the reset settings, from zero history
   task automatic test_median_cases();
      logic signed [SAMPLE_W-1:0] values[$];
      values = '{16'sh7FFF, -16'sh8000, -16'sh8000, 16'sh7FFF, 16'sh7FFF,
                 16'sd1, -16'sd1, 16'sd0, 16'sd5, 16'sd3, 16'sd4, 16'sd4, 16'sd4,
                 16'sd10, 16'sd20, 16'sd30, 16'sd20, 16'sd10};
      foreach (values[i])
         send_word(values[i]);
      idle_requests(1);
   endtask

   // Register extremes, ignored high bits and unknown indexes
   task automatic test_register_extremes();
      write_register(CSR_RATE_SCALE, 32'h0000_0000);
      send_word(16'sh7FFF);
      send_word(-16'sh8000);
      idle_requests(1);
      write_register(CSR_RATE_SCALE, 32'hABCD_FFFF);
      write_register(CSR_TIME_STEP, 32'hFFFF_FFFF);
      write_register(CSR_DRIFT_PER_STEP, 32'h5A5A_0000);
      send_word(-16'sh8000);
      send_word(-16'sh8000);
      send_word(16'sh7FFF);
      send_word(16'sh7FFF);
      idle_requests(1);
      write_register(CSR_TIME_STEP, 32'h0000_0000);
      write_register(CSR_DRIFT_PER_STEP, 32'h1234_FFFF);
      send_word(16'sh1234);
      send_word(-16'sh1234);
      idle_requests(1);
      write_register(CSR_INDEX_W'(3), 32'hFFFF_FFFF);
      write_register('1, 32'h0000_0001);
      send_word(16'sh4000);
      idle_requests(1);
   endtask

   // Random samples under several random register settings
   task automatic test_random_settings();
      repeat (6) begin
         write_register(CSR_RATE_SCALE, pick_register_value(SCALE_W));
         write_register(CSR_TIME_STEP, pick_register_value(STEP_W));
         write_register(CSR_DRIFT_PER_STEP, pick_register_value(DRIFT_W));
         send_stream($urandom_range(20, 40), SAMPLES_ANY, 0);
      end
   endtask

   // Hold the receiver off while words keep coming, so the input stalls
   task automatic test_backpressure();
      hold_off_asked++;
      repeat (24) send_word(pick_sample(SAMPLES_ANY));
      idle_requests(1);
   endtask

   // Drive the accumulator into the lower limit, hold it there, then climb off it
   task automatic test_angle_limits();
      write_register(CSR_RATE_SCALE, 32'h0000_FFFF);
      write_register(CSR_TIME_STEP, 32'hFFFF_FFFF);
      write_register(CSR_DRIFT_PER_STEP, 32'h0000_0000);
      send_stream(400, SAMPLES_HIGH, 4);
      write_register(CSR_DRIFT_PER_STEP, 32'h0000_FFFF);
      send_stream(30, SAMPLES_LOW, 0);
      send_stream(20, SAMPLES_ANY, 0);
   endtask

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_raw_rate = '0;
      csr_valid    = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      model_cfg    = '{RATE_SCALE_RST, TIME_STEP_RST, DRIFT_PER_STEP_RST};
      model_history[0] = '0;
      model_history[1] = '0;
      model_angle  = 0;
      clip_count   = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_median_cases();
      test_register_extremes();
      test_random_settings();
      test_backpressure();
      test_angle_limits();

      wait_until_idle();
      if (pending_results.size() != 0)
         note_error($sformatf("ERROR: %0d expected results never arrived",
                              pending_results.size()));
      if (error_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
